@@ rtl/core/awga_pkg.sv @@
// Package for the alpha-weighted grid averager.
// Holds widths, accumulator and control structs, and the size clamp.
// Used by every module of the block; depends on nothing.
package awga_pkg;

    localparam int DIM_W     = 11;
    localparam int GRID_W    = 7;
    localparam int CELL_W    = 6;
    localparam int COMP_W    = 16;
    localparam int PROD_W    = 2 * COMP_W;
    localparam int CSUM_W    = 52;
    localparam int ASUM_W    = 36;
    localparam int DEPTH     = 64;
    localparam int ADDR_W    = 6;
    localparam int MAX_DIM   = 1024;
    localparam int MAX_CELLS = 64;
    localparam int DIM_STEPS = DIM_W;
    localparam int QUO_STEPS = COMP_W;
    localparam int CNT_W     = 5;
    localparam int NCOLOR    = 3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GRID   = 2'd2;

    // One accumulator entry: three weighted color sums and the alpha sum.
    typedef struct packed {
        logic [CSUM_W-1:0] sr;
        logic [CSUM_W-1:0] sg;
        logic [CSUM_W-1:0] sb;
        logic [ASUM_W-1:0] sa;
    } t_acc;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic restart;
        logic dim_load;
        logic dim_step;
        logic pix_take;
        logic acc_do;
        logic quo_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pix_emit;
        logic out_free;
    } t_sts;

    // A size of zero acts as one, and sizes above the maximum saturate.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/alpha_weighted_grid_average.sv @@
// Alpha-weighted grid averager, top level: configuration registers, controller, datapath.
// Each pixel passes capture, multiply and read, and accumulate in turn; a pixel that
// closes a cell adds the bit-serial mean divider and an output step.
// After reset or any write to a defined register, the image size is divided by the grid count
// before pixels are accepted. Reset is synchronous, active low, and clears all sums.
// Depends on awga_pkg, awga_ctrl and awga_datapath.
module alpha_weighted_grid_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // pixel_red, pixel_green, pixel_blue, pixel_alpha
    // Cell stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // cell_col, cell_row, avg_red, avg_green, avg_blue, pad
    output logic        o_m_tlast,   // last_cell
    output logic        o_m_tuser,   // no_coverage
    // Configuration port.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [awga_pkg::DIM_W-1:0]  r_width;
    logic [awga_pkg::DIM_W-1:0]  r_height;
    logic [awga_pkg::GRID_W-1:0] r_grid;
    logic                        w_cfg_wr;
    logic [1:0]                  w_idx;
    awga_pkg::t_cmd              w_cmd;
    awga_pkg::t_sts              w_sts;

    assign o_pready = 1'b1;
    assign w_idx    = i_paddr[3:2];
    assign w_cfg_wr = i_psel && i_penable && i_pwrite &&
                      ((w_idx == awga_pkg::REG_WIDTH) || (w_idx == awga_pkg::REG_HEIGHT) ||
                       (w_idx == awga_pkg::REG_GRID));

    // Register writes; any write to one of the three registers restarts the image.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= awga_pkg::DIM_W'(16);
            r_height <= awga_pkg::DIM_W'(16);
            r_grid   <= awga_pkg::GRID_W'(1);
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (w_idx)
                awga_pkg::REG_WIDTH:  r_width  <= i_pwdata[awga_pkg::DIM_W-1:0];
                awga_pkg::REG_HEIGHT: r_height <= i_pwdata[awga_pkg::DIM_W-1:0];
                awga_pkg::REG_GRID:   r_grid   <= i_pwdata[awga_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (w_idx)
            awga_pkg::REG_WIDTH:  o_prdata = {21'b0, r_width};
            awga_pkg::REG_HEIGHT: o_prdata = {21'b0, r_height};
            awga_pkg::REG_GRID:   o_prdata = {25'b0, r_grid};
            default:              o_prdata = '0;
        endcase
    end

    awga_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (w_cfg_wr),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_s_tready (o_s_tready)
    );

    awga_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_grid     (r_grid),
        .i_pix      (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // A register write holds off pixels while the cell size is recomputed.
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> !o_s_tready)
        else $error("pixel accepted right after a register write");

    // A cell is only loaded when the output register can take it.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("cell loaded over an untaken result");

    // The sequencer issues at most one datapath phase per cycle.
    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.pix_take, w_cmd.acc_do, w_cmd.quo_step, w_cmd.out_load,
                  w_cmd.dim_step}))
        else $error("overlapping datapath commands");

endmodule

@@ rtl/core/awga_ctrl.sv @@
// Controller state machine for the alpha-weighted grid averager.
// Sequences cell-size division, accumulation, mean division and output.
// Depends on awga_pkg.
module awga_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr,
    input  logic            i_s_tvalid,
    input  awga_pkg::t_sts  i_sts,
    output awga_pkg::t_cmd  o_cmd,
    output logic            o_s_tready
);

    typedef enum logic [2:0] {
        S_DIM,
        S_IDLE,
        S_MUL,
        S_ACC,
        S_QUO,
        S_WAIT
    } t_state;

    t_state                       r_state;
    logic [awga_pkg::CNT_W-1:0]   r_cnt;

    assign o_s_tready = (r_state == S_IDLE);

    // Commands decode from the state and the step counter.
    always_comb begin
        o_cmd          = '0;
        o_cmd.restart  = i_cfg_wr;
        o_cmd.dim_load = (r_state == S_DIM) && (r_cnt == '0);
        o_cmd.dim_step = (r_state == S_DIM) && (r_cnt != '0);
        o_cmd.pix_take = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.acc_do   = (r_state == S_ACC);
        o_cmd.quo_step = (r_state == S_QUO);
        o_cmd.out_load = (r_state == S_WAIT) && i_sts.out_free;
    end

    // State register and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DIM;
            r_cnt   <= '0;
        end else if (i_cfg_wr) begin
            r_state <= S_DIM;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_DIM: begin
                    if (r_cnt == awga_pkg::CNT_W'(awga_pkg::DIM_STEPS)) begin
                        r_state <= S_IDLE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_cnt   <= '0;
                    r_state <= i_sts.pix_emit ? S_QUO : S_IDLE;
                end
                S_QUO: begin
                    if (r_cnt == awga_pkg::CNT_W'(awga_pkg::QUO_STEPS - 1)) begin
                        r_state <= S_WAIT;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_DIM;
                    r_cnt   <= '0;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/awga_datapath.sv @@
// Datapath of the alpha-weighted grid averager: cell-size divider, position
// counters, accumulator memory, bit-serial mean divider and output register.
// Depends on awga_pkg.
module awga_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  awga_pkg::t_cmd                    i_cmd,
    output awga_pkg::t_sts                    o_sts,
    input  logic [awga_pkg::DIM_W-1:0]        i_width,
    input  logic [awga_pkg::DIM_W-1:0]        i_height,
    input  logic [awga_pkg::GRID_W-1:0]       i_grid,
    input  logic [4*awga_pkg::COMP_W-1:0]     i_pix,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [63:0]                       o_m_tdata,
    output logic                              o_m_tlast,
    output logic                              o_m_tuser
);

    localparam int DW = awga_pkg::DIM_W;
    localparam int GW = awga_pkg::GRID_W;
    localparam int CW = awga_pkg::COMP_W;
    localparam int SW = awga_pkg::CSUM_W;
    localparam int AW = awga_pkg::ASUM_W;
    localparam int NC = awga_pkg::NCOLOR;

    logic [DW-1:0] w_wc;
    logic [DW-1:0] w_hc;
    logic [DW-1:0] w_g_ext;
    logic          w_g_ok;

    assign w_wc    = awga_pkg::clamp_dim(i_width);
    assign w_hc    = awga_pkg::clamp_dim(i_height);
    assign w_g_ext = {{(DW-GW){1'b0}}, i_grid};
    assign w_g_ok  = (i_grid != '0) && (i_grid <= GW'(awga_pkg::MAX_CELLS)) &&
                     (w_g_ext <= w_wc) && (w_g_ext <= w_hc);

    // Cell width and height: restoring division of the sizes by the grid count.
    logic [DW-1:0] r_cw;
    logic [DW-1:0] r_ch;
    logic [GW-1:0] r_wrem;
    logic [GW-1:0] r_hrem;
    logic [GW:0]   w_wt;
    logic [GW:0]   w_ht;
    logic          w_wge;
    logic          w_hge;

    assign w_wt  = {r_wrem, r_cw[DW-1]};
    assign w_ht  = {r_hrem, r_ch[DW-1]};
    assign w_wge = (w_wt >= {1'b0, i_grid});
    assign w_hge = (w_ht >= {1'b0, i_grid});

    always_ff @(posedge i_clk) begin
        if (i_cmd.dim_load) begin
            r_cw   <= w_wc;
            r_ch   <= w_hc;
            r_wrem <= '0;
            r_hrem <= '0;
        end else if (i_cmd.dim_step) begin
            r_wrem <= w_wge ? GW'(w_wt - {1'b0, i_grid}) : w_wt[GW-1:0];
            r_hrem <= w_hge ? GW'(w_ht - {1'b0, i_grid}) : w_ht[GW-1:0];
            r_cw   <= {r_cw[DW-2:0], w_wge};
            r_ch   <= {r_ch[DW-2:0], w_hge};
        end
    end

    // Raster position, position inside the cell and cell index on each axis.
    logic [DW-1:0] r_x, r_xin, r_y, r_yin;
    logic [GW-1:0] r_cx, r_cy;
    logic          w_x_end, w_y_end, w_xin_end, w_yin_end;

    assign w_x_end   = (r_x == w_wc - 1'b1);
    assign w_y_end   = (r_y == w_hc - 1'b1);
    assign w_xin_end = (r_xin == r_cw - 1'b1);
    assign w_yin_end = (r_yin == r_ch - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_x   <= '0;
            r_xin <= '0;
            r_cx  <= '0;
            r_y   <= '0;
            r_yin <= '0;
            r_cy  <= '0;
        end else if (i_cmd.pix_take) begin
            if (w_x_end) begin
                r_x   <= '0;
                r_xin <= '0;
                r_cx  <= '0;
                if (w_y_end) begin
                    r_y   <= '0;
                    r_yin <= '0;
                    r_cy  <= '0;
                end else begin
                    r_y <= r_y + 1'b1;
                    if (w_yin_end) begin
                        r_yin <= '0;
                        r_cy  <= (r_cy < i_grid) ? r_cy + 1'b1 : r_cy;
                    end else begin
                        r_yin <= r_yin + 1'b1;
                    end
                end
            end else begin
                r_x <= r_x + 1'b1;
                if (w_xin_end) begin
                    r_xin <= '0;
                    r_cx  <= (r_cx < i_grid) ? r_cx + 1'b1 : r_cx;
                end else begin
                    r_xin <= r_xin + 1'b1;
                end
            end
        end
    end

    // Pixel capture with its cell and its role in the cell.
    logic [CW-1:0]               r_pr, r_pg, r_pb, r_pa;
    logic [awga_pkg::ADDR_W-1:0] r_pcx, r_pcy;
    logic                        r_p_hit, r_p_emit, r_p_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_take) begin
            r_pr     <= i_pix[CW-1:0];
            r_pg     <= i_pix[2*CW-1:CW];
            r_pb     <= i_pix[3*CW-1:2*CW];
            r_pa     <= i_pix[4*CW-1:3*CW];
            r_pcx    <= r_cx[awga_pkg::ADDR_W-1:0];
            r_pcy    <= r_cy[awga_pkg::ADDR_W-1:0];
            r_p_hit  <= w_g_ok && (r_cx < i_grid) && (r_cy < i_grid);
            r_p_emit <= w_xin_end && w_yin_end;
            r_p_last <= (r_cx == i_grid - 1'b1) && (r_cy == i_grid - 1'b1);
        end
    end

    // Products and the accumulator read, registered together.
    logic [awga_pkg::PROD_W-1:0] r_mr, r_mg, r_mb;
    awga_pkg::t_acc              r_mem [awga_pkg::DEPTH];
    awga_pkg::t_acc              r_rd;
    logic [awga_pkg::DEPTH-1:0]  r_vld;
    logic                        r_rd_vld;

    always_ff @(posedge i_clk) begin
        r_mr     <= r_pr * r_pa;
        r_mg     <= r_pg * r_pa;
        r_mb     <= r_pb * r_pa;
        r_rd     <= r_mem[r_pcx];
        r_rd_vld <= r_vld[r_pcx];
    end

    // Accumulate; an entry that is not valid reads as zero.
    awga_pkg::t_acc w_base;
    awga_pkg::t_acc w_sum;

    always_comb begin
        w_base   = r_rd_vld ? r_rd : '0;
        w_sum.sr = w_base.sr + SW'(r_mr);
        w_sum.sg = w_base.sg + SW'(r_mg);
        w_sum.sb = w_base.sb + SW'(r_mb);
        w_sum.sa = w_base.sa + AW'(r_pa);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_do && r_p_hit) begin
            r_mem[r_pcx] <= w_sum;
        end
    end

    // An emitted cell leaves its entry invalid, which reads as cleared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_vld <= '0;
        end else if (i_cmd.acc_do && r_p_hit) begin
            r_vld[r_pcx] <= !r_p_emit;
        end
    end

    assign o_sts.pix_emit = r_p_hit && r_p_emit;

    // Mean division: one quotient bit per step for the three colors.
    logic [AW-1:0]               r_qrem [NC];
    logic [CW-1:0]               r_qlo  [NC];
    logic [AW-1:0]               r_den;
    logic                        r_nc;
    logic                        r_olast;
    logic [awga_pkg::ADDR_W-1:0] r_ocx, r_ocy;
    logic [AW:0]                 w_qt   [NC];
    logic                        w_qge  [NC];

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            w_qt[c]  = {r_qrem[c], r_qlo[c][CW-1]};
            w_qge[c] = (w_qt[c] >= {1'b0, r_den});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_do && r_p_hit && r_p_emit) begin
            r_qrem[0] <= w_sum.sr[SW-1:CW];
            r_qrem[1] <= w_sum.sg[SW-1:CW];
            r_qrem[2] <= w_sum.sb[SW-1:CW];
            r_qlo[0]  <= w_sum.sr[CW-1:0];
            r_qlo[1]  <= w_sum.sg[CW-1:0];
            r_qlo[2]  <= w_sum.sb[CW-1:0];
            r_den     <= w_sum.sa;
            r_nc      <= (w_sum.sa == '0);
            r_ocx     <= r_pcx;
            r_ocy     <= r_pcy;
            r_olast   <= r_p_last;
        end else if (i_cmd.quo_step) begin
            for (int c = 0; c < NC; c++) begin
                r_qrem[c] <= w_qge[c] ? AW'(w_qt[c] - {1'b0, r_den}) : w_qt[c][AW-1:0];
                r_qlo[c]  <= {r_qlo[c][CW-2:0], w_qge[c]};
            end
        end
    end

    // Output register; a finished cell waits here until its transfer.
    logic r_ovalid;

    assign o_sts.out_free = !r_ovalid || i_m_tready;
    assign o_m_tvalid     = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_m_tdata <= {4'b0,
                          r_nc ? {CW{1'b0}} : r_qlo[2],
                          r_nc ? {CW{1'b0}} : r_qlo[1],
                          r_nc ? {CW{1'b0}} : r_qlo[0],
                          r_ocy, r_ocx};
            o_m_tlast <= r_olast;
            o_m_tuser <= r_nc;
        end
    end

endmodule

@@ tb/tb_alpha_weighted_grid_average.sv @@
// Testbench for the alpha-weighted grid averager: drives RGBA pixel transfers and
// register writes, predicts each finished cell and checks the cell stream.
// Depends on awga_pkg and alpha_weighted_grid_average.

class cell_scoreboard;
    // Predictor state: configuration, position and per-column sums.
    int unsigned img_w, img_h, grid_n;
    int unsigned px, py;
    logic [127:0] acc_r[64], acc_g[64], acc_b[64], acc_a[64];
    logic [63:0] want_q[$];
    logic want_last_q[$];
    logic want_nc_q[$];
    int errors;
    int cells_seen;

    function void clear_image();
        px = 0;
        py = 0;
        for (int i = 0; i < 64; i++) begin
            acc_r[i] = '0;
            acc_g[i] = '0;
            acc_b[i] = '0;
            acc_a[i] = '0;
        end
    endfunction

    function void reset_state();
        img_w = 16;
        img_h = 16;
        grid_n = 1;
        errors = 0;
        cells_seen = 0;
        clear_image();
    endfunction

    function void write_reg(int unsigned idx, logic [31:0] v);
        if (idx == awga_pkg::REG_WIDTH) img_w = v[10:0];
        else if (idx == awga_pkg::REG_HEIGHT) img_h = v[10:0];
        else if (idx == awga_pkg::REG_GRID) grid_n = v[6:0];
        clear_image();
    endfunction

    static function int unsigned fix_dim(int unsigned v);
        if (v == 0) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    // Note one accepted pixel transfer and queue the cell it finishes, if any.
    function void note_pixel(logic [63:0] d);
        int unsigned w, h, cw, ch, cx, cy;
        logic [127:0] a;
        logic [63:0] exp_d;
        logic [15:0] qr, qg, qb;
        logic nc;
        logic lc;
        w = fix_dim(img_w);
        h = fix_dim(img_h);
        if (grid_n >= 1 && grid_n <= 64 && grid_n <= w && grid_n <= h) begin
            cw = w / grid_n;
            ch = h / grid_n;
            cx = px / cw;
            cy = py / ch;
            if (cx < grid_n && cy < grid_n) begin
                a = 128'(d[63:48]);
                acc_r[cx] += 128'(d[15:0]) * a;
                acc_g[cx] += 128'(d[31:16]) * a;
                acc_b[cx] += 128'(d[47:32]) * a;
                acc_a[cx] += a;
                if (px == cw * (cx + 1) - 1 && py == ch * (cy + 1) - 1) begin
                    qr = 0; qg = 0; qb = 0; nc = 1;
                    if (acc_a[cx] != 0) begin
                        qr = 16'(acc_r[cx] / acc_a[cx]);
                        qg = 16'(acc_g[cx] / acc_a[cx]);
                        qb = 16'(acc_b[cx] / acc_a[cx]);
                        nc = 0;
                    end
                    exp_d = {4'd0, qb, qg, qr, 6'(cy), 6'(cx)};
                    lc = (cx == grid_n - 1 && cy == grid_n - 1);
                    want_q = {want_q, exp_d};
                    want_nc_q = {want_nc_q, nc};
                    want_last_q = {want_last_q, lc};
                    acc_r[cx] = 0; acc_g[cx] = 0; acc_b[cx] = 0; acc_a[cx] = 0;
                end
            end
        end
        px++;
        if (px >= w) begin
            px = 0;
            py++;
            if (py >= h) py = 0;
        end
    endfunction

    // Compare one cell transfer with the oldest expected cell.
    function void check_cell(logic [63:0] d, logic last, logic nc, longint t);
        logic [63:0] e;
        logic el, en;
        cells_seen++;
        if (want_q.size() == 0) begin
            $display("%0d: unexpected cell, actual %h", t, d);
            errors++;
            return;
        end
        e = want_q.pop_front();
        el = want_last_q.pop_front();
        en = want_nc_q.pop_front();
        if (d !== e) begin
            $display("%0d: cell data mismatch, expected %h actual %h", t, e, d);
            errors++;
        end
        if (last !== el) begin
            $display("%0d: last_cell mismatch, expected %b actual %b", t, el, last);
            errors++;
        end
        if (nc !== en) begin
            $display("%0d: no_coverage mismatch, expected %b actual %b", t, en, nc);
            errors++;
        end
    endfunction
endclass

module tb_alpha_weighted_grid_average;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [63:0] s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [63:0] m_data;
    logic        m_last, m_user;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cell_scoreboard sb;
    longint cycles = 0;
    int pixels_sent = 0;
    int rx_mode = 0;     // 0 random idling, 1 no idling, 2 long hold-off
    int tx_idle_pct = 19;
    int settings_run = 0;

    alpha_weighted_grid_average i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .o_m_tlast(m_last), .o_m_tuser(m_user),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // Cycle limit: generous against the slowest correct run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sample both streams at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && s_ready) sb.note_pixel(s_data);
        if (i_rst_n && m_valid && m_ready) sb.check_cell(m_data, m_last, m_user, cycles);
    end

    // Receiver: random idling, a clean stretch, or a long hold-off.
    always @(negedge i_clk) begin
        if (rx_mode == 2) m_ready <= 1'b0;
        else if (rx_mode == 1) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 19);
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Offer one pixel and hold it until its transfer.
    task automatic send_pixel(input logic [63:0] d);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 0;
            @(negedge i_clk);
        end
        s_valid <= 1;
        s_data <= d;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        pixels_sent++;
        @(negedge i_clk);
        s_valid <= 0;
    endtask

    function automatic logic [63:0] rand_pixel();
        logic [63:0] d;
        int k;
        d = {$urandom, $urandom};
        k = $urandom_range(9);
        if (k == 0) d[63:48] = 16'h0000;
        else if (k == 1) d[63:48] = 16'hFFFF;
        else if (k == 2) d = '1;
        return d;
    endfunction

    // Wait for all queued cells, then for the divider to drain.
    task automatic drain();
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic configure(input int w, input int h, input int g);
        drain();
        reg_write(awga_pkg::REG_WIDTH, w);
        reg_write(awga_pkg::REG_HEIGHT, h);
        reg_write(awga_pkg::REG_GRID, g);
        settings_run++;
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) send_pixel(rand_pixel());
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: reset setting, extremes of the components, zero alpha.
        send_pixel('0);
        send_pixel('1);
        send_pixel(64'h0000_FFFF_FFFF_FFFF);
        send_pixel(64'hFFFF_0000_0000_0000);
        send_pixel(64'h0001_FFFF_0000_FFFF);
        send_pixel(64'h8000_1234_5678_9ABC);
        configure(2, 2, 2);
        repeat (4) send_pixel('0);              // every cell uncovered
        repeat (4) send_pixel('1);
        configure(3, 2, 4);                     // grid larger than image
        repeat (6) send_pixel('1);
        configure(0, 0, 1);                     // sizes of zero act as one
        send_pixel(64'hFFFF_AAAA_5555_FFFF);
        send_pixel(64'h0000_AAAA_5555_FFFF);
        configure(5, 4, 0);                     // grid of zero
        repeat (3) send_pixel('1);
        configure(2047, 1, 127);                // oversize values saturate or disable
        repeat (3) send_pixel('1);

        // Random phases with small images, the last grid count near its limit.
        configure(5, 3, 2); send_random(45);
        configure(4, 4, 4); send_random(40);
        configure(7, 6, 3); send_random(60);
        tx_idle_pct = 0; rx_mode = 1;
        configure(8, 8, 8); send_random(64);     // no idling at all
        tx_idle_pct = 19; rx_mode = 0;
        configure(64, 64, 64); send_random(200); // largest grid
        // Long receiver hold-off while the sender keeps offering.
        configure(2, 2, 2);
        fork
            begin
                rx_mode = 2;
                repeat (200) @(posedge i_clk);
                rx_mode = 0;
            end
            send_random(40);
        join
        // Sender waits for every expected cell before resuming.
        drain();
        configure(9, 5, 5); send_random(90);
        // A write in the middle of an image restarts it.
        configure(6, 6, 3); send_random(13);
        configure(6, 6, 2); send_random(80);
        configure(1024, 2, 1); send_random(100); // widest row, one cell
        configure(3, 3, 1); send_random(90);

        drain();
        $display("Covered %0d pixels and %0d cells over %0d register settings.",
                 pixels_sent, sb.cells_seen, settings_run);
        if (sb.errors == 0 && sb.want_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
